[hw/rtl/wis_pkg.sv]
// ----------------------------------------------------------------------------
// wis_pkg
// Shared constants and field layout for the weighted index sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package wis_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int WEIGHT_BITS   = 32;
    localparam int FRACTION_BITS = 24;

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W    = WEIGHT_BITS + IDX_W;
    localparam int HI_W     = SUM_W - FRACTION_BITS;
    localparam int MUL_B_W  = (HI_W > FRACTION_BITS) ? HI_W : FRACTION_BITS;
    localparam int PROD_W   = FRACTION_BITS + MUL_B_W;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 24;
    localparam int ID_W     = 25;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 24'd100000;

    // slave tdata: flux_weight, uniform_value
    localparam int S_DATA_W = ((WEIGHT_BITS + FRACTION_BITS + 7) / 8) * 8;

    // master tdata: source_index, identifier, entry_count
    localparam int M_IDX_LSB   = 0;
    localparam int M_ID_LSB    = IDX_W;
    localparam int M_CNT_LSB   = IDX_W + ID_W;
    localparam int M_FIELDS_W  = IDX_W + ID_W + CNT_W;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_DRAW   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd3;

endpackage

`default_nettype wire

[hw/rtl/wis_ram.sv]
// ----------------------------------------------------------------------------
// wis_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module wis_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/wis_scale.sv]
// ----------------------------------------------------------------------------
// wis_scale
// Scales the running total by a fraction, floor(u * t / 2^F), using one
// shared multiplier over two partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module wis_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [wis_pkg::FRACTION_BITS-1:0] i_frac,
    input  logic [wis_pkg::SUM_W-1:0]         i_total,
    output logic                              o_done,
    output logic [wis_pkg::SUM_W-1:0]         o_scaled
);

    import wis_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_SUM} t_phase;

    t_phase                   r_phase;
    logic                     r_done;
    logic [FRACTION_BITS-1:0] r_frac;
    logic [SUM_W-1:0]         r_total;
    logic [MUL_B_W-1:0]       r_acc;
    logic [SUM_W-1:0]         r_prod;
    logic [SUM_W-1:0]         r_scaled;

    logic [MUL_B_W-1:0]       mul_b;
    logic [PROD_W-1:0]        product;

    always_comb begin
        if (r_phase == PH_LO) begin
            mul_b = MUL_B_W'(r_total[FRACTION_BITS-1:0]);
        end else begin
            mul_b = MUL_B_W'(r_total[SUM_W-1:FRACTION_BITS]);
        end
        product = PROD_W'(r_frac) * PROD_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_frac  <= i_frac;
                        r_total <= i_total;
                        r_phase <= PH_LO;
                    end
                end
                PH_LO: begin
                    r_acc   <= product[PROD_W-1:FRACTION_BITS];
                    r_phase <= PH_HI;
                end
                PH_HI: begin
                    r_prod  <= product[SUM_W-1:0];
                    r_phase <= PH_SUM;
                end
                PH_SUM: begin
                    r_scaled <= r_prod + SUM_W'(r_acc);
                    r_done   <= 1'b1;
                    r_phase  <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_scaled = r_scaled;

endmodule

`default_nettype wire

[hw/rtl/weighted_index_sampler.sv]
// ----------------------------------------------------------------------------
// weighted_index_sampler
// Weighted random index selection over a table of cumulative weight sums.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command per transaction: tuser selects clear,
//   append or draw; tdata carries the weight (append) and the uniform
//   fraction (draw). Every command returns exactly one master transaction
//   with status in tuser and index, identifier and entry count in tdata.
//   The identifier offset is written through i_cfg_wr_en/i_cfg_wr_data,
//   by the user only while no command is in flight; the block does not check.
// Processing:
//   Clear, append and unused commands go straight to the finish state on
//   acceptance. A draw first scales its fraction by the total, then runs
//   a binary search of k steps with k <= ceil(log2(count + 1)); the
//   search does one RAM read per cycle and the scaling runs its low, high
//   and sum phases on a shared multiplier. One command is processed at a
//   time; s_axis_tready is high whenever the engine is idle.
// Reset / stall:
//   Reset empties the table (count and total zero) and restores the offset
//   to 100000; the RAM is not cleared. A stalled master side holds the
//   output register; the next command is still taken and its result waits
//   in the engine until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_index_sampler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [31:0] flux_weight, [55:32] uniform_value
    input  logic [wis_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [wis_pkg::OP_W-1:0]     s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [9:0] source_index, [34:10] identifier, [45:35] entry_count
    output logic [wis_pkg::M_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [wis_pkg::STATUS_W-1:0] m_axis_tuser,
    input  logic                         i_cfg_wr_en,
    input  logic [wis_pkg::OFFSET_W-1:0] i_cfg_wr_data
);

    import wis_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCALE, S_SEARCH, S_FINISH} t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SUM_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_hi, n_hi;
    logic [OFFSET_W-1:0] r_offset;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [IDX_W-1:0]    r_res_index, n_res_index;
    logic [ID_W-1:0]     r_res_ident, n_res_ident;
    logic                r_m_valid, n_m_valid;
    logic [STATUS_W-1:0] r_m_status;
    logic [IDX_W-1:0]    r_m_index;
    logic [ID_W-1:0]     r_m_ident;
    logic [CNT_W-1:0]    r_m_count;

    logic                     in_fire;
    logic                     load_out;
    logic [OP_W-1:0]          op;
    logic [WEIGHT_BITS-1:0]   weight;
    logic [FRACTION_BITS-1:0] frac;
    logic [SUM_W-1:0]         sum_next;
    logic [CNT_W-1:0]         mid_cur;
    logic [CNT_W-1:0]         mid_next;
    logic [CNT_W-1:0]         sel_index;
    logic                     above;

    logic                     ram_wr_en;
    logic                     ram_rd_en;
    logic [IDX_W-1:0]         ram_rd_addr;
    logic [SUM_W-1:0]         ram_rd_data;

    logic                     scale_start;
    logic                     scale_done;
    logic [SUM_W-1:0]         scaled;

    function automatic logic [CNT_W-1:0] midpoint(input logic [CNT_W-1:0] lo,
                                                  input logic [CNT_W-1:0] hi);
        return lo + ((hi - lo) >> 1);
    endfunction

    wis_ram #(
        .WIDTH (SUM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (sum_next),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    wis_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scale_start),
        .i_frac   (frac),
        .i_total  (r_total),
        .o_done   (scale_done),
        .o_scaled (scaled)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser;
    assign weight        = s_axis_tdata[WEIGHT_BITS-1:0];
    assign frac          = s_axis_tdata[WEIGHT_BITS +: FRACTION_BITS];
    assign sum_next      = r_total + SUM_W'(weight);
    assign mid_cur       = midpoint(r_lo, r_hi);
    assign above         = (ram_rd_data > scaled);
    assign load_out      = (r_state == S_FINISH) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_ident  = r_res_ident;
        n_m_valid    = r_m_valid && !m_axis_tready;
        ram_wr_en    = 1'b0;
        scale_start  = 1'b0;
        sel_index    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res_status = STATUS_OK;
                    n_res_index  = '0;
                    n_res_ident  = '0;
                    n_state      = S_FINISH;
                    case (op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                        end
                        OP_APPEND: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_res_status = STATUS_FULL;
                            end else begin
                                ram_wr_en = 1'b1;
                                n_total   = sum_next;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        OP_DRAW: begin
                            if (r_count == '0) begin
                                n_res_status = STATUS_EMPTY;
                            end else if (r_total == '0) begin
                                n_res_status = STATUS_ZERO;
                            end else begin
                                scale_start = 1'b1;
                                n_state     = S_SCALE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCALE: begin
                if (scale_done) begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (above) begin
                    n_hi = mid_cur;
                end else begin
                    n_lo = mid_cur + CNT_W'(1);
                end
                if (n_lo >= n_hi) begin
                    sel_index   = (n_lo >= r_count) ? (r_count - CNT_W'(1)) : n_lo;
                    n_res_index = sel_index[IDX_W-1:0];
                    n_res_ident = ID_W'(sel_index[IDX_W-1:0]) + ID_W'(r_offset);
                    n_state     = S_FINISH;
                end
            end
            S_FINISH: begin
                if (load_out) begin
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign mid_next    = midpoint(n_lo, n_hi);
    assign ram_rd_en   = (n_state == S_SEARCH);
    assign ram_rd_addr = mid_next[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_total   <= '0;
            r_offset  <= OFFSET_RESET;
            r_m_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_total      <= n_total;
            r_m_valid    <= n_m_valid;
            r_lo         <= n_lo;
            r_hi         <= n_hi;
            r_res_status <= n_res_status;
            r_res_index  <= n_res_index;
            r_res_ident  <= n_res_ident;
            if (i_cfg_wr_en) begin
                r_offset <= i_cfg_wr_data;
            end
            if (load_out) begin
                r_m_status <= r_res_status;
                r_m_index  <= r_res_index;
                r_m_ident  <= r_res_ident;
                r_m_count  <= r_count;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = M_DATA_W'({r_m_count, r_m_ident, r_m_index});

endmodule

`default_nettype wire

[hw/rtl/wis_checker.sv]
// ----------------------------------------------------------------------------
// wis_checker
// Port-level checks on the result stream of the weighted index sampler.
// ----------------------------------------------------------------------------
`default_nettype none

module wis_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [wis_pkg::M_DATA_W-1:0] m_axis_tdata,
    input wire logic [wis_pkg::STATUS_W-1:0] m_axis_tuser
);

    import wis_pkg::*;

    logic [IDX_W-1:0] idx;
    logic [ID_W-1:0]  ident;
    logic [CNT_W-1:0] cnt;

    assign idx   = m_axis_tdata[M_IDX_LSB +: IDX_W];
    assign ident = m_axis_tdata[M_ID_LSB +: ID_W];
    assign cnt   = m_axis_tdata[M_CNT_LSB +: CNT_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> cnt <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_index_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (cnt != '0) |-> CNT_W'(idx) < cnt)
        else $error("index outside held entries");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (idx == '0) && (ident == '0))
        else $error("nonzero index on failed transaction");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |-> cnt == CNT_W'(TABLE_DEPTH))
        else $error("full status with table not full");

endmodule

bind weighted_index_sampler wis_checker u_wis_checker (.*);

`default_nettype wire

[dv/tb_weighted_index_sampler.sv]
// ----------------------------------------------------------------------------
// tb_weighted_index_sampler
// Self-checking bench for the weighted index sampler. Commands go in on the
// slave stream; a scoreboard model of the cumulative table predicts status,
// index, identifier and entry count of untyped rows; typed rows carry their
// own. A directed table comes first, then random command mixes under several
// offsets, with random stalls on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_weighted_index_sampler;
    import wis_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam int              WATCHDOG_T   = 2000000;
    localparam int              SETTLE_CYCLES = 24;
    localparam int              HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [ID_W-1:0]     ident;
        logic [CNT_W-1:0]    count;
    } t_sample;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [WEIGHT_BITS-1:0]   weight;
        logic [FRACTION_BITS-1:0] frac;
        bit                       typed;
        t_sample                  want;
    } t_cmd_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0]     s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                i_cfg_wr_en = 1'b0;
    logic [OFFSET_W-1:0] i_cfg_wr_data = '0;

    // scoreboard model state
    logic [SUM_W-1:0]    cum_sums [TABLE_DEPTH];
    logic [CNT_W-1:0]    held = '0;
    logic [SUM_W-1:0]    total = '0;
    logic [OFFSET_W-1:0] id_offset = OFFSET_RESET;

    t_sample  sample_q [$];
    t_cmd_row directed [$];
    t_sample  got, want;
    int       fail_count = 0;
    bit       idle_on = 1'b1;
    int       rx_hold_len = 0;

    weighted_index_sampler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #WATCHDOG_T;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_sample predict_sample(input logic [OP_W-1:0] op,
                                               input logic [WEIGHT_BITS-1:0] weight,
                                               input logic [FRACTION_BITS-1:0] frac);
        t_sample                        r;
        logic [FRACTION_BITS+SUM_W-1:0] prod;
        logic [SUM_W-1:0]               target;
        int                             lo, hi, mid;
        r = '0;
        case (op)
            OP_CLEAR: begin
                held  = '0;
                total = '0;
            end
            OP_APPEND: begin
                if (held >= TABLE_DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    total          = total + weight;
                    cum_sums[held] = total;
                    held           = held + 1'b1;
                end
            end
            OP_DRAW: begin
                if (held == 0) begin
                    r.status = STATUS_EMPTY;
                end else if (total == 0) begin
                    r.status = STATUS_ZERO;
                end else begin
                    prod   = frac * total;
                    target = prod >> FRACTION_BITS;
                    lo = 0;
                    hi = held;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (cum_sums[mid] > target) hi = mid;
                        else lo = mid + 1;
                    end
                    if (lo >= held) lo = held - 1;
                    r.status = STATUS_OK;
                    r.index  = lo[IDX_W-1:0];
                    r.ident  = r.index + id_offset;
                end
            end
            default: ;
        endcase
        r.count = held;
        return r;
    endfunction

    function automatic t_cmd_row mk_row(input logic [OP_W-1:0] op,
                                        input logic [WEIGHT_BITS-1:0] weight,
                                        input logic [FRACTION_BITS-1:0] frac,
                                        input bit typed,
                                        input logic [STATUS_W-1:0] status,
                                        input logic [IDX_W-1:0] index,
                                        input logic [ID_W-1:0] ident,
                                        input logic [CNT_W-1:0] count);
        t_cmd_row c;
        c.op     = op;
        c.weight = weight;
        c.frac   = frac;
        c.typed  = typed;
        c.want   = '{status: status, index: index, ident: ident, count: count};
        return c;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] random_weight();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return '0;
        if (pick < 4) return $urandom_range(0, 15);
        if (pick < 6) return $urandom_range(0, 1000);
        return $urandom;
    endfunction

    function automatic logic [FRACTION_BITS-1:0] random_frac();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return FRACTION_BITS'($urandom_range(0, (1 << FRACTION_BITS) - 1));
    endfunction

    function automatic t_cmd_row random_row();
        int pick;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 3)       op = OP_CLEAR;
        else if (pick < 42) op = OP_APPEND;
        else if (pick < 97) op = OP_DRAW;
        else                op = OP_UNUSED;
        return mk_row(op, random_weight(), random_frac(), 1'b0, STATUS_OK, '0, '0, '0);
    endfunction

    task automatic add_row(input t_cmd_row c);
        directed.insert(directed.size(), c);
    endtask

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    // one slave transaction; the prediction is taken at acceptance
    task automatic issue(input t_cmd_row c);
        t_sample p;
        if (idle_on && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 17));
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.frac, c.weight};
        s_axis_tuser  <= c.op;
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_sample(c.op, c.weight, c.frac);
        sample_q.insert(sample_q.size(), c.typed ? c.want : p);
    endtask

    task automatic drain();
        idle_sender(1);
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        id_offset = v;
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.index  = m_axis_tdata[M_IDX_LSB +: IDX_W];
            got.ident  = m_axis_tdata[M_ID_LSB +: ID_W];
            got.count  = m_axis_tdata[M_CNT_LSB +: CNT_W];
            if (sample_q.size() == 0) begin
                note_failure($sformatf("unexpected transaction st=%0d idx=%0d id=%0d cnt=%0d",
                                       got.status, got.index, got.ident, got.count));
            end else begin
                want = sample_q.pop_front();
                if (got !== want)
                    note_failure($sformatf({"st exp %0d got %0d, idx exp %0d got %0d, ",
                                            "id exp %0d got %0d, cnt exp %0d got %0d"},
                                           want.status, got.status, want.index, got.index,
                                           want.ident, got.ident, want.count, got.count));
            end
        end
    end

    // output ready: random stall bursts, plus a long hold-off on request
    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                stall_left  = rx_hold_len;
                rx_hold_len = 0;
            end
            if (stall_left == 0 && run_left == 0) begin
                if (idle_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 17);
                else run_left = $urandom_range(1, 30);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                run_left--;
            end
        end
    end

    initial begin
        // directed table, reset offset in effect
        add_row(mk_row(OP_DRAW,   '0,           '0,         1, STATUS_EMPTY, 0, 0, 0));
        add_row(mk_row(OP_APPEND, '0,           '0,         1, STATUS_OK,    0, 0, 1));
        add_row(mk_row(OP_DRAW,   '0,           24'd123,    1, STATUS_ZERO,  0, 0, 1));
        add_row(mk_row(OP_UNUSED, '0,           '0,         1, STATUS_OK,    0, 0, 1));
        add_row(mk_row(OP_APPEND, 32'hFFFFFFFF, '0,         1, STATUS_OK,    0, 0, 2));
        add_row(mk_row(OP_DRAW,   '0,           '0,         1, STATUS_OK,    1,
                       ID_W'(OFFSET_RESET) + ID_W'(1), 2));
        add_row(mk_row(OP_DRAW,   '0,           24'hFFFFFF, 1, STATUS_OK,    1,
                       ID_W'(OFFSET_RESET) + ID_W'(1), 2));
        add_row(mk_row(OP_APPEND, '0,           '0,         1, STATUS_OK,    0, 0, 3));
        add_row(mk_row(OP_DRAW,   '0,           24'hFFFFFF, 0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_CLEAR,  '0,           '0,         1, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_DRAW,   '0,           24'h800000, 1, STATUS_EMPTY, 0, 0, 0));
        add_row(mk_row(OP_APPEND, 32'd1,        '0,         1, STATUS_OK,    0, 0, 1));
        add_row(mk_row(OP_APPEND, 32'd1,        '0,         1, STATUS_OK,    0, 0, 2));
        add_row(mk_row(OP_APPEND, 32'd2,        '0,         1, STATUS_OK,    0, 0, 3));
        add_row(mk_row(OP_DRAW,   '0,           '0,         0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_DRAW,   '0,           24'h800000, 0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_DRAW,   '0,           24'h400000, 0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_DRAW,   '0,           24'hFFFFFF, 0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_APPEND, 32'hFFFFFFFF, '0,         0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_APPEND, 32'h80000000, '0,         0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_APPEND, 32'd1,        '0,         0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_DRAW,   '0,           24'hAAAAAA, 0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_DRAW,   '0,           24'h555555, 0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_UNUSED, 32'hFFFFFFFF, 24'hFFFFFF, 0, STATUS_OK,    0, 0, 0));
        add_row(mk_row(OP_CLEAR,  32'hFFFFFFFF, 24'hFFFFFF, 0, STATUS_OK,    0, 0, 0));

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) issue(directed[i]);

        // random mix with the largest offset
        write_offset('1);
        repeat (60) issue(random_row());

        // random mix, zero offset, with a long output hold-off
        write_offset('0);
        issue(mk_row(OP_CLEAR, '0, '0, 0, STATUS_OK, 0, 0, 0));
        repeat (100) issue(random_row());
        idle_on     = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        repeat (20) issue(random_row());
        idle_on = 1'b1;
        repeat (100) issue(random_row());
        drain();
        repeat (20) issue(random_row());

        // random offset
        write_offset(OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1)));
        repeat (100) issue(random_row());
        idle_on = 1'b0;
        repeat (60) issue(random_row());

        idle_sender(1);
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
